// ===== rtl/mtp_pkg.sv =====
// ============================================================================
// mtp_pkg: shared types and constants of the multiline tag parser
// Holds the character codes, result kinds, parser modes, the request format
// passed from the parsing front end to the emitting back end, and the
// name buffer write port format.
// ============================================================================
package mtp_pkg;

  // Name buffer geometry.
  localparam int NAME_MAX = 32;
  localparam int NAME_AW  = $clog2(NAME_MAX);
  localparam int NAME_CW  = $clog2(NAME_MAX + 1);

  // Indent counters.
  localparam int                IND_W           = 10;
  localparam logic [IND_W-1:0] NO_LIMIT_INDENT = IND_W'(999);
  localparam logic [IND_W-1:0] INDENT_SAT      = IND_W'(1023);

  // Request queue between front and back end.
  localparam int QDEPTH = 2;
  localparam int QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCW    = $clog2(QDEPTH + 1);

  // Character codes.
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_DASH  = 8'h2D;

  // Result kinds.
  localparam logic [1:0] KIND_NAME     = 2'd0;
  localparam logic [1:0] KIND_NAME_END = 2'd1;
  localparam logic [1:0] KIND_BODY     = 2'd2;
  localparam logic [1:0] KIND_TAG_END  = 2'd3;

  typedef enum logic [2:0] {
    MODE_NAME,
    MODE_AFTER,
    MODE_COPY,
    MODE_LSTART,
    MODE_LEAD
  } mode_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_END,
    BK_NAME,
    BK_CMPL,
    BK_BODY
  } bk_state_t;

  // One request describes every result caused by one input byte.
  typedef struct packed {
    logic               has_end;
    logic               has_name;
    logic               has_body;
    logic [NAME_CW-1:0] name_len;
    logic               trunc;
    logic [7:0]         body_byte;
  } cmd_t;

  typedef struct packed {
    logic               en;
    logic [NAME_AW-1:0] addr;
    logic [7:0]         data;
  } name_wr_t;

  function automatic logic is_name_char(logic [7:0] b);
    return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A)) ||
           ((b >= 8'h30) && (b <= 8'h39)) || (b == CH_UNDER) || (b == CH_DASH);
  endfunction

endpackage

// ===== rtl/mtp_front.sv =====
// ============================================================================
// mtp_front: parsing front end
// Accepts stream bytes, runs the line parser and writes name bytes into the
// name buffer. Every byte that causes results becomes one queue request.
// ============================================================================
module mtp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_byte,
  input  logic              in_end_of_input,
  input  logic              q_full,
  output logic              q_push,
  output mtp_pkg::cmd_t     q_cmd,
  output mtp_pkg::name_wr_t name_wr,
  input  logic              name_done
);

  mtp_pkg::mode_t                    mode_r, mode_nxt;
  logic [mtp_pkg::NAME_CW-1:0]       name_count_r, name_count_nxt;
  logic                              all_legal_r, all_legal_nxt;
  logic                              overflow_r, overflow_nxt;
  logic                              first_pending_r, first_pending_nxt;
  logic [mtp_pkg::IND_W-1:0]         hang_r, hang_nxt;
  logic [mtp_pkg::IND_W-1:0]         seen_r, seen_nxt;
  logic                              tag_open_r, tag_open_nxt;
  logic                              name_busy_r, name_busy_nxt;

  logic                              acc;
  logic                              is_ws, is_nl, is_colon, is_nc;
  logic                              closing, do_lead, do_search;
  logic [mtp_pkg::NAME_CW-1:0]       srch_cnt;
  logic                              srch_legal, srch_ovf;
  logic [mtp_pkg::IND_W-1:0]         lead_seen;
  mtp_pkg::mode_t                    lead_mode;
  logic                              search_open;

  // Input is held off while a name burst drains or the queue is full.
  assign in_stall = name_busy_r || q_full;
  assign acc      = in_valid && !in_stall;

  assign is_ws    = (in_byte == mtp_pkg::CH_SPACE) || (in_byte == mtp_pkg::CH_TAB);
  assign is_nl    = (in_byte == mtp_pkg::CH_NL);
  assign is_colon = (in_byte == mtp_pkg::CH_COLON);
  assign is_nc    = mtp_pkg::is_name_char(in_byte);

  // A closing line starts a fresh search with a cleared name.
  assign closing    = !in_end_of_input && (mode_r == mtp_pkg::MODE_LSTART) && !is_ws && !is_nl;
  assign do_lead    = !in_end_of_input &&
                      ((mode_r == mtp_pkg::MODE_LEAD) ||
                       ((mode_r == mtp_pkg::MODE_LSTART) && (is_ws || is_nl)));
  assign do_search  = !in_end_of_input && (closing ||
                      ((mode_r != mtp_pkg::MODE_AFTER) && (mode_r != mtp_pkg::MODE_COPY) &&
                       (mode_r != mtp_pkg::MODE_LSTART) && (mode_r != mtp_pkg::MODE_LEAD)));
  assign srch_cnt   = (mode_r == mtp_pkg::MODE_LSTART) ? '0 : name_count_r;
  assign srch_legal = (mode_r == mtp_pkg::MODE_LSTART) ? 1'b1 : all_legal_r;
  assign srch_ovf   = (mode_r == mtp_pkg::MODE_LSTART) ? 1'b0 : overflow_r;
  assign lead_seen  = (mode_r == mtp_pkg::MODE_LSTART) ? '0 : seen_r;
  assign search_open = srch_legal && is_colon;

  always_comb begin
    if (first_pending_r) begin
      if (is_ws) begin
        lead_mode = mtp_pkg::MODE_LEAD;
      end else if (is_nl) begin
        lead_mode = mtp_pkg::MODE_LSTART;
      end else begin
        lead_mode = mtp_pkg::MODE_COPY;
      end
    end else if (is_ws && (lead_seen < hang_r)) begin
      lead_mode = mtp_pkg::MODE_LEAD;
    end else if (is_nl) begin
      lead_mode = mtp_pkg::MODE_LSTART;
    end else begin
      lead_mode = mtp_pkg::MODE_COPY;
    end
  end

  // Next parser mode.
  always_comb begin
    mode_nxt = mode_r;
    if (acc) begin
      if (in_end_of_input) begin
        mode_nxt = mtp_pkg::MODE_NAME;
      end else begin
        case (mode_r)
          mtp_pkg::MODE_AFTER: begin
            if (is_nl) begin
              mode_nxt = mtp_pkg::MODE_LSTART;
            end else if (!is_ws) begin
              mode_nxt = mtp_pkg::MODE_COPY;
            end
          end
          mtp_pkg::MODE_COPY: begin
            if (is_nl) begin
              mode_nxt = mtp_pkg::MODE_LSTART;
            end
          end
          mtp_pkg::MODE_LSTART: begin
            if (is_ws || is_nl) begin
              mode_nxt = lead_mode;
            end else begin
              mode_nxt = search_open ? mtp_pkg::MODE_AFTER : mtp_pkg::MODE_NAME;
            end
          end
          mtp_pkg::MODE_LEAD: begin
            mode_nxt = lead_mode;
          end
          default: begin
            mode_nxt = search_open ? mtp_pkg::MODE_AFTER : mtp_pkg::MODE_NAME;
          end
        endcase
      end
    end
  end

  // Datapath state, requests and name buffer writes.
  always_comb begin
    name_count_nxt    = name_count_r;
    all_legal_nxt     = all_legal_r;
    overflow_nxt      = overflow_r;
    first_pending_nxt = first_pending_r;
    hang_nxt          = hang_r;
    seen_nxt          = seen_r;
    tag_open_nxt      = tag_open_r;
    q_cmd             = '0;
    name_wr           = '0;

    if (acc && in_end_of_input) begin
      q_cmd.has_end  = tag_open_r;
      tag_open_nxt   = 1'b0;
      name_count_nxt = '0;
      all_legal_nxt  = 1'b1;
      overflow_nxt   = 1'b0;
    end

    if (acc && !in_end_of_input && (mode_r == mtp_pkg::MODE_AFTER) && !is_ws && !is_nl) begin
      q_cmd.has_body    = 1'b1;
      q_cmd.body_byte   = in_byte;
      first_pending_nxt = 1'b0;
      hang_nxt          = mtp_pkg::NO_LIMIT_INDENT;
    end

    if (acc && !in_end_of_input && (mode_r == mtp_pkg::MODE_COPY)) begin
      q_cmd.has_body  = 1'b1;
      q_cmd.body_byte = in_byte;
    end

    if (acc && closing) begin
      q_cmd.has_end  = 1'b1;
      tag_open_nxt   = 1'b0;
      name_count_nxt = '0;
      all_legal_nxt  = 1'b1;
      overflow_nxt   = 1'b0;
    end

    if (acc && do_lead) begin
      seen_nxt = lead_seen;
      if (first_pending_r) begin
        if (is_ws) begin
          seen_nxt = (lead_seen == mtp_pkg::INDENT_SAT) ? lead_seen
                                                         : lead_seen + mtp_pkg::IND_W'(1);
        end else if (!is_nl) begin
          hang_nxt          = lead_seen;
          first_pending_nxt = 1'b0;
          q_cmd.has_body    = 1'b1;
          q_cmd.body_byte   = in_byte;
        end
      end else if (is_ws && (lead_seen < hang_r)) begin
        seen_nxt = lead_seen + mtp_pkg::IND_W'(1);
      end else begin
        q_cmd.has_body  = 1'b1;
        q_cmd.body_byte = in_byte;
      end
    end

    if (acc && do_search) begin
      if (is_nl) begin
        name_count_nxt = '0;
        all_legal_nxt  = 1'b1;
        overflow_nxt   = 1'b0;
      end else if (srch_legal) begin
        if (is_colon) begin
          q_cmd.has_name    = 1'b1;
          q_cmd.name_len    = srch_cnt;
          q_cmd.trunc       = srch_ovf;
          name_count_nxt    = '0;
          all_legal_nxt     = 1'b1;
          overflow_nxt      = 1'b0;
          tag_open_nxt      = 1'b1;
          first_pending_nxt = 1'b1;
          hang_nxt          = '0;
          seen_nxt          = '0;
        end else if (!is_nc) begin
          all_legal_nxt = 1'b0;
        end else if (srch_cnt < mtp_pkg::NAME_CW'(mtp_pkg::NAME_MAX)) begin
          name_wr.en     = 1'b1;
          name_wr.addr   = srch_cnt[mtp_pkg::NAME_AW-1:0];
          name_wr.data   = in_byte;
          name_count_nxt = srch_cnt + mtp_pkg::NAME_CW'(1);
        end else begin
          overflow_nxt = 1'b1;
        end
      end
    end
  end

  assign q_push = q_cmd.has_end || q_cmd.has_name || q_cmd.has_body;

  always_comb begin
    name_busy_nxt = name_busy_r;
    if (acc && q_cmd.has_name) begin
      name_busy_nxt = 1'b1;
    end else if (name_done) begin
      name_busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r          <= mtp_pkg::MODE_NAME;
      name_count_r    <= '0;
      all_legal_r     <= 1'b1;
      overflow_r      <= 1'b0;
      first_pending_r <= 1'b1;
      hang_r          <= '0;
      seen_r          <= '0;
      tag_open_r      <= 1'b0;
      name_busy_r     <= 1'b0;
    end else begin
      mode_r          <= mode_nxt;
      name_count_r    <= name_count_nxt;
      all_legal_r     <= all_legal_nxt;
      overflow_r      <= overflow_nxt;
      first_pending_r <= first_pending_nxt;
      hang_r          <= hang_nxt;
      seen_r          <= seen_nxt;
      tag_open_r      <= tag_open_nxt;
      name_busy_r     <= name_busy_nxt;
    end
  end

  // Any mode other than name search means a tag is open.
  a_open_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r != mtp_pkg::MODE_NAME) |-> tag_open_r)
    else $error("parser mode left name search without an open tag");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    name_count_r <= mtp_pkg::NAME_CW'(mtp_pkg::NAME_MAX))
    else $error("name count beyond buffer size");

  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    name_done |-> name_busy_r)
    else $error("name burst finished while none was pending");

endmodule

// ===== rtl/mtp_queue.sv =====
// ============================================================================
// mtp_queue: request queue
// Short register FIFO that decouples the parsing front end from the back end.
// ============================================================================
module mtp_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  mtp_pkg::cmd_t push_cmd,
  input  logic          pop,
  output mtp_pkg::cmd_t head,
  output logic          full,
  output logic          empty
);

  mtp_pkg::cmd_t              entry_r [mtp_pkg::QDEPTH];
  logic [mtp_pkg::QAW-1:0]    wp_r, wp_nxt;
  logic [mtp_pkg::QAW-1:0]    rp_r, rp_nxt;
  logic [mtp_pkg::QCW-1:0]    cnt_r, cnt_nxt;
  logic                       do_push, do_pop;

  assign full    = (cnt_r == mtp_pkg::QCW'(mtp_pkg::QDEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entry_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == mtp_pkg::QAW'(mtp_pkg::QDEPTH - 1)) ? '0 : wp_r + mtp_pkg::QAW'(1);
    end
    if (do_pop) begin
      rp_nxt = (rp_r == mtp_pkg::QAW'(mtp_pkg::QDEPTH - 1)) ? '0 : rp_r + mtp_pkg::QAW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + mtp_pkg::QCW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - mtp_pkg::QCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wp_r] <= push_cmd;
    end
  end

endmodule

// ===== rtl/mtp_back.sv =====
// ============================================================================
// mtp_back: emitting back end
// Owns the name buffer, takes requests from the queue and plays each one out
// as a run of results into the output register.
// ============================================================================
module mtp_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  mtp_pkg::cmd_t     q_head,
  output logic              q_pop,
  input  mtp_pkg::name_wr_t name_wr,
  output logic              name_done,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_byte,
  output logic [1:0]        out_kind,
  output logic              out_last_of_run,
  output logic              out_name_truncated
);

  mtp_pkg::bk_state_t             state_r, state_nxt, phase_after;
  mtp_pkg::cmd_t                  cmd_r;
  logic [mtp_pkg::NAME_AW-1:0]    np_r, np_nxt;
  logic [7:0]                     name_mem [mtp_pkg::NAME_MAX];
  logic [7:0]                     rd_data_r;

  logic                           out_valid_r;
  logic [7:0]                     out_byte_r, out_byte_nxt;
  logic [1:0]                     out_kind_r, out_kind_nxt;
  logic                           out_last_r;
  logic                           out_trunc_r, out_trunc_nxt;
  logic                           out_free, emit;

  function automatic mtp_pkg::bk_state_t first_phase(mtp_pkg::cmd_t c);
    if (c.has_end) begin
      return mtp_pkg::BK_END;
    end else if (c.has_name) begin
      return (c.name_len != '0) ? mtp_pkg::BK_NAME : mtp_pkg::BK_CMPL;
    end else if (c.has_body) begin
      return mtp_pkg::BK_BODY;
    end
    return mtp_pkg::BK_IDLE;
  endfunction

  assign out_free = !out_valid_r || !out_stall;
  assign emit     = (state_r != mtp_pkg::BK_IDLE) && out_free;

  // Phase that follows the current one within the loaded request.
  always_comb begin
    case (state_r)
      mtp_pkg::BK_END: begin
        if (cmd_r.has_name) begin
          phase_after = (cmd_r.name_len != '0) ? mtp_pkg::BK_NAME : mtp_pkg::BK_CMPL;
        end else begin
          phase_after = cmd_r.has_body ? mtp_pkg::BK_BODY : mtp_pkg::BK_IDLE;
        end
      end
      mtp_pkg::BK_NAME: begin
        phase_after = (mtp_pkg::NAME_CW'(np_r) + mtp_pkg::NAME_CW'(1) == cmd_r.name_len)
                      ? mtp_pkg::BK_CMPL : mtp_pkg::BK_NAME;
      end
      mtp_pkg::BK_CMPL: begin
        phase_after = cmd_r.has_body ? mtp_pkg::BK_BODY : mtp_pkg::BK_IDLE;
      end
      default: begin
        phase_after = mtp_pkg::BK_IDLE;
      end
    endcase
  end

  // A new request is loaded when idle or as the last result of the old one goes out.
  assign q_pop = !q_empty &&
                 ((state_r == mtp_pkg::BK_IDLE) || (emit && (phase_after == mtp_pkg::BK_IDLE)));

  always_comb begin
    state_nxt = state_r;
    if (q_pop) begin
      state_nxt = first_phase(q_head);
    end else if (emit) begin
      state_nxt = phase_after;
    end
  end

  // Result for the current phase.
  always_comb begin
    out_byte_nxt  = '0;
    out_kind_nxt  = mtp_pkg::KIND_BODY;
    out_trunc_nxt = 1'b0;
    case (state_r)
      mtp_pkg::BK_END: begin
        out_kind_nxt = mtp_pkg::KIND_TAG_END;
      end
      mtp_pkg::BK_NAME: begin
        out_kind_nxt = mtp_pkg::KIND_NAME;
        out_byte_nxt = rd_data_r;
      end
      mtp_pkg::BK_CMPL: begin
        out_kind_nxt  = mtp_pkg::KIND_NAME_END;
        out_trunc_nxt = cmd_r.trunc;
      end
      mtp_pkg::BK_BODY: begin
        out_byte_nxt = cmd_r.body_byte;
      end
      default: begin
        out_kind_nxt = mtp_pkg::KIND_BODY;
      end
    endcase
  end

  assign name_done = emit && (state_r == mtp_pkg::BK_CMPL);

  always_comb begin
    np_nxt = np_r;
    if (q_pop) begin
      np_nxt = '0;
    end else if (emit && (state_r == mtp_pkg::BK_NAME)) begin
      np_nxt = np_r + mtp_pkg::NAME_AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mtp_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    np_r <= np_nxt;
    if (q_pop) begin
      cmd_r <= q_head;
    end
    if (emit) begin
      out_byte_r  <= out_byte_nxt;
      out_kind_r  <= out_kind_nxt;
      out_last_r  <= (phase_after == mtp_pkg::BK_IDLE);
      out_trunc_r <= out_trunc_nxt;
    end
  end

  // Name buffer; the read always follows the next name pointer.
  always_ff @(posedge clk) begin
    if (name_wr.en) begin
      name_mem[name_wr.addr] <= name_wr.data;
    end
    rd_data_r <= name_mem[np_nxt];
  end

  assign out_valid          = out_valid_r;
  assign out_byte           = out_byte_r;
  assign out_kind           = out_kind_r;
  assign out_last_of_run    = out_last_r;
  assign out_name_truncated = out_trunc_r;

  a_np_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mtp_pkg::BK_NAME) |-> (mtp_pkg::NAME_CW'(np_r) < cmd_r.name_len))
    else $error("name pointer ran past the name length");

  a_trunc_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_kind_r != mtp_pkg::KIND_NAME_END)) |-> !out_trunc_r)
    else $error("truncation flag on a result that is not name complete");

  a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && ((out_kind_r == mtp_pkg::KIND_NAME_END) ||
                     (out_kind_r == mtp_pkg::KIND_TAG_END))) |-> (out_byte_r == 8'h00))
    else $error("marker result carries a nonzero byte");

endmodule

// ===== rtl/multiline_tag_parser.sv =====
// ============================================================================
// multiline_tag_parser: finds "name: body" tags in a text byte stream
// Top level joining the parsing front end, request queue and emitting back end.
// ============================================================================
// The block takes one text byte per request and returns tag results: name
// bytes, a name-complete marker, body bytes with the hanging indent stripped,
// and a tag-end marker. Body text flows at one byte per cycle while the output
// is not stalled and the queue is not full. At the colon that closes a name,
// the buffered name is played out of the name buffer one byte per cycle
// through its single read port while the output is not stalled, and the
// input stays stalled until the name-complete marker has gone out.
// Requests still waiting in the queue and a stalled output lengthen that
// stall. A request with in_end_of_input set closes an open tag and clears
// a partial name. The name buffer needs no clearing after reset; the block
// is ready as reset ends.
module multiline_tag_parser (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_input,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic [1:0] out_kind,
  output logic       out_last_of_run,
  output logic       out_name_truncated
);

  // Requests from the front end to the back end, one per byte that has results.
  mtp_pkg::cmd_t     push_cmd;
  mtp_pkg::cmd_t     head_cmd;
  logic              q_push, q_pop, q_full, q_empty;

  // The front end writes name bytes straight into the back end's buffer.
  mtp_pkg::name_wr_t name_wr;
  // Pulses when the name-complete marker leaves, releasing the input.
  logic              name_done;

  // The front end parses each accepted byte in its cycle and holds the
  // parser state: mode, name count and flags, and the indent counters.
  mtp_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte         (in_byte),
    .in_end_of_input (in_end_of_input),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_cmd           (push_cmd),
    .name_wr         (name_wr),
    .name_done       (name_done)
  );

  // The queue lets the front end run ahead while results wait on out_stall.
  mtp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head     (head_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  // The back end turns each request into its run of results and marks the
  // final one of the run.
  mtp_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (q_empty),
    .q_head             (head_cmd),
    .q_pop              (q_pop),
    .name_wr            (name_wr),
    .name_done          (name_done),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_byte           (out_byte),
    .out_kind           (out_kind),
    .out_last_of_run    (out_last_of_run),
    .out_name_truncated (out_name_truncated)
  );

endmodule
